FILE: hw/rtl/frame_buffer_pool_manager_defines.svh
// Assertion macros for the frame buffer pool manager checker.
// Standalone header; included by the checker file only.
`ifndef FRAME_BUFFER_POOL_MANAGER_DEFINES_SVH
`define FRAME_BUFFER_POOL_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define FBPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define FBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/fbpm_pkg.sv
// Shared types and constants for the frame buffer pool manager.
// No dependencies; compiled first.
package fbpm_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int ID_W        = 4;
  localparam int LEVEL_W     = 5;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
  localparam int PTR_W       = $clog2(NUM_BUFFERS);
  // Pool size after reset: sixteen buffers, saturated to the store depth
  localparam int INIT_N      = (NUM_BUFFERS < 16) ? NUM_BUFFERS : 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_STORE   = 2'd1,
    FUNC_LOAD    = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RECLAIMED = 2'd1,
    ST_NONE      = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Free stack controls and status
  typedef struct packed {
    logic             init;
    logic [CNT_W-1:0] init_n;
    logic             push;
    logic             pop;
    logic [ID_W-1:0]  wr_id;
  } fs_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  top_id;
  } fs_stat_t;

  // Work queue controls and status
  typedef struct packed {
    logic            init;
    logic            push;
    logic            pop;
    logic [ID_W-1:0] wr_id;
  } wq_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  head_id;
  } wq_stat_t;

endpackage

FILE: hw/rtl/fbpm_if.sv
// Valid/ready channel interfaces for the operation and result items.
// Depends on fbpm_pkg for field widths.
interface fbpm_in_if;
  import fbpm_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ID_W-1:0]     buffer_id;

  modport source (output valid, output func, output buffer_id, input ready);
  modport sink   (input valid, input func, input buffer_id, output ready);
endinterface

interface fbpm_out_if;
  import fbpm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     result_id;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0]  free_level;
  logic [LEVEL_W-1:0]  queued_level;

  modport source (output valid, output result_id, output status, output free_level,
                  output queued_level, input ready);
  modport sink   (input valid, input result_id, input status, input free_level,
                  input queued_level, output ready);
endinterface

FILE: hw/rtl/fbpm_free_stack.sv
// Last-in-first-out free buffer stack held in flip-flops, with its fill count.
// Depends on fbpm_pkg.
module fbpm_free_stack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpm_pkg::fs_ctrl_t ctrl_i,
  output fbpm_pkg::fs_stat_t stat_o
);
  import fbpm_pkg::*;

  logic [ID_W-1:0]  stack_q [NUM_BUFFERS];
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_idx;
  logic [PTR_W-1:0] top_idx;

  // Push lands at the count, the top sits one below
  assign wr_idx  = count_q[PTR_W-1:0];
  assign top_idx = PTR_W'(wr_idx - 1'b1);

  assign stat_o.count  = count_q;
  assign stat_o.top_id = stack_q[top_idx];

  // Advance the fill count
  always_comb begin
    count_d = count_q;
    priority if (ctrl_i.init) begin
      count_d = ctrl_i.init_n;
    end else if (ctrl_i.pop) begin
      count_d = CNT_W'(count_q - 1'b1);
    end else if (ctrl_i.push) begin
      count_d = CNT_W'(count_q + 1'b1);
    end
  end

  // Refill with ids in order on init, write the pushed id otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(INIT_N);
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        stack_q[i] <= ID_W'(i);
      end
    end else begin
      count_q <= count_d;
      if (ctrl_i.init) begin
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          stack_q[i] <= ID_W'(i);
        end
      end else if (ctrl_i.push) begin
        stack_q[wr_idx] <= ctrl_i.wr_id;
      end
    end
  end

endmodule

FILE: hw/rtl/fbpm_work_queue.sv
// First-in-first-out work queue of filled buffer ids, with head, tail and count.
// Depends on fbpm_pkg.
module fbpm_work_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpm_pkg::wq_ctrl_t ctrl_i,
  output fbpm_pkg::wq_stat_t stat_o
);
  import fbpm_pkg::*;

  logic [ID_W-1:0]  mem_q [NUM_BUFFERS];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] head_inc, tail_inc;

  // Wrap pointers at the queue depth
  assign head_inc = (head_q == PTR_W'(NUM_BUFFERS - 1)) ? '0 : PTR_W'(head_q + 1'b1);
  assign tail_inc = (tail_q == PTR_W'(NUM_BUFFERS - 1)) ? '0 : PTR_W'(tail_q + 1'b1);

  assign stat_o.count   = count_q;
  assign stat_o.head_id = mem_q[head_q];

  // Advance pointers and count
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    priority if (ctrl_i.init) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (ctrl_i.pop) begin
      head_d  = head_inc;
      count_d = CNT_W'(count_q - 1'b1);
    end else if (ctrl_i.push) begin
      tail_d  = tail_inc;
      count_d = CNT_W'(count_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Write the stored id at the tail
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.init) begin
      mem_q[tail_q] <= ctrl_i.wr_id;
    end
  end

endmodule

FILE: hw/rtl/frame_buffer_pool_manager.sv
// Channel   | Dir | Payload                                         | Handshake
// item_i    | in  | func, buffer_id                                 | valid/ready
// result_o  | out | result_id, status, free_level, queued_level     | valid/ready
// cfg       | in  | cfg_wdata_i (pool size)                         | cfg_we_i
//
// One item per cycle while the result is not stalled: an input register, a decode/update step, a result register.
// An accepted item waits in the input register until it fires; its result is then registered.
// The stores update as the result register loads, so the next item sees the new state.
// A stalled result holds the input register; ready drops only when both are full.
// Reset fills the free stack with ids 0..15 (15 on top) and empties the queue.
// Top level of the buffer pool manager; depends on fbpm_pkg, fbpm_if,
// fbpm_free_stack and fbpm_work_queue.
module frame_buffer_pool_manager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fbpm_in_if.sink                        item_i,
  fbpm_out_if.source                     result_o,
  input  logic                           cfg_we_i,
  input  logic [fbpm_pkg::LEVEL_W-1:0]   cfg_wdata_i
);
  import fbpm_pkg::*;

  // Input register
  logic              in_vld_q;
  logic [FUNC_W-1:0] in_func_q;
  logic [ID_W-1:0]   in_id_q;

  // Result register
  logic               out_vld_q;
  logic [ID_W-1:0]    rid_q, rid_d;
  status_e            status_q, status_d;
  logic [LEVEL_W-1:0] free_lvl_q, free_lvl_d;
  logic [LEVEL_W-1:0] queued_lvl_q, queued_lvl_d;

  logic     fire;
  logic     in_take;
  logic     pool_init;
  logic [CNT_W-1:0] pool_n;
  fs_ctrl_t fs_ctrl;
  fs_stat_t fs_stat;
  wq_ctrl_t wq_ctrl;
  wq_stat_t wq_stat;
  logic     fs_empty, fs_full, wq_empty, wq_full;

  fbpm_free_stack u_free_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fs_ctrl),
    .stat_o (fs_stat)
  );

  fbpm_work_queue u_work_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (wq_ctrl),
    .stat_o (wq_stat)
  );

  // Handshake: process when the result slot is free or being drained
  assign fire         = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || fire;
  assign in_take      = item_i.valid && item_i.ready;

  // Pool size write: zero is ignored, oversize saturates
  assign pool_init = cfg_we_i && (cfg_wdata_i != '0);
  assign pool_n    = (32'(cfg_wdata_i) > NUM_BUFFERS) ? CNT_W'(NUM_BUFFERS)
                                                      : CNT_W'(cfg_wdata_i);

  assign fs_empty = (fs_stat.count == '0);
  assign fs_full  = (fs_stat.count == CNT_W'(NUM_BUFFERS));
  assign wq_empty = (wq_stat.count == '0);
  assign wq_full  = (wq_stat.count == CNT_W'(NUM_BUFFERS));

  // Decode the held item into store controls and the result
  always_comb begin
    logic [CNT_W-1:0] free_next;
    logic [CNT_W-1:0] queued_next;

    fs_ctrl        = '0;
    wq_ctrl        = '0;
    fs_ctrl.init   = pool_init;
    fs_ctrl.init_n = pool_n;
    fs_ctrl.wr_id  = in_id_q;
    wq_ctrl.init   = pool_init;
    wq_ctrl.wr_id  = in_id_q;
    rid_d          = '0;
    status_d       = ST_OK;

    unique case (func_e'(in_func_q))
      FUNC_ALLOC: begin
        if (!fs_empty) begin
          fs_ctrl.pop = fire;
          rid_d       = fs_stat.top_id;
        end else if (!wq_empty) begin
          wq_ctrl.pop = fire;
          rid_d       = wq_stat.head_id;
          status_d    = ST_RECLAIMED;
        end else begin
          status_d    = ST_NONE;
        end
      end
      FUNC_STORE: begin
        if (wq_full) begin
          status_d     = ST_FULL;
        end else begin
          wq_ctrl.push = fire;
        end
      end
      FUNC_LOAD: begin
        if (!wq_empty) begin
          wq_ctrl.pop = fire;
          rid_d       = wq_stat.head_id;
        end else begin
          status_d    = ST_NONE;
        end
      end
      FUNC_RELEASE: begin
        if (fs_full) begin
          status_d     = ST_FULL;
        end else begin
          fs_ctrl.push = fire;
        end
      end
    endcase

    // Levels after this item
    free_next   = fs_stat.count;
    queued_next = wq_stat.count;
    if (fs_ctrl.pop) begin
      free_next = CNT_W'(fs_stat.count - 1'b1);
    end else if (fs_ctrl.push) begin
      free_next = CNT_W'(fs_stat.count + 1'b1);
    end
    if (wq_ctrl.pop) begin
      queued_next = CNT_W'(wq_stat.count - 1'b1);
    end else if (wq_ctrl.push) begin
      queued_next = CNT_W'(wq_stat.count + 1'b1);
    end
    free_lvl_d   = LEVEL_W'(free_next);
    queued_lvl_d = LEVEL_W'(queued_next);
  end

  // Control: input and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: capture the item, then the result
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q <= item_i.func;
      in_id_q   <= item_i.buffer_id;
    end
    if (fire) begin
      rid_q        <= rid_d;
      status_q     <= status_d;
      free_lvl_q   <= free_lvl_d;
      queued_lvl_q <= queued_lvl_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.result_id    = rid_q;
  assign result_o.status       = status_q;
  assign result_o.free_level   = free_lvl_q;
  assign result_o.queued_level = queued_lvl_q;

endmodule

FILE: hw/rtl/fbpm_checker.sv
// Port-level checks for the buffer pool manager, bound to the top level.
// Depends on fbpm_pkg and frame_buffer_pool_manager_defines.svh.
`include "frame_buffer_pool_manager_defines.svh"

module fbpm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [fbpm_pkg::STATUS_W-1:0] out_status_i,
  input logic [fbpm_pkg::LEVEL_W-1:0]  out_free_level_i,
  input logic [fbpm_pkg::LEVEL_W-1:0]  out_queued_level_i
);
  import fbpm_pkg::*;

  // A full report means the targeted store holds every buffer
  `FBPM_ASSERT_NOW(a_full_at_depth, clk_i, rst_ni, out_valid_i && (out_status_i == ST_FULL), (out_free_level_i == LEVEL_W'(NUM_BUFFERS)) || (out_queued_level_i == LEVEL_W'(NUM_BUFFERS)))

  // Reclaiming from the queue only happens with an empty free stack
  `FBPM_ASSERT_NOW(a_reclaim_free_empty, clk_i, rst_ni, out_valid_i && (out_status_i == ST_RECLAIMED), out_free_level_i == '0)

  // Load reports none only on an empty queue; allocate on both empty
  `FBPM_ASSERT_NOW(a_none_queue_empty, clk_i, rst_ni, out_valid_i && (out_status_i == ST_NONE), out_queued_level_i == '0)

  // A stalled result stays offered
  `FBPM_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind frame_buffer_pool_manager fbpm_checker u_fbpm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (result_o.valid),
  .out_ready_i        (result_o.ready),
  .out_status_i       (result_o.status),
  .out_free_level_i   (result_o.free_level),
  .out_queued_level_i (result_o.queued_level)
);
